// ----- rtl/rost_pkg.sv -----
// Shared types and constants for the ray/oriented-box slab test.
// Used by rost_smul, rost_sdiv and ray_obb_slab_test; no dependencies.
package rost_pkg;

    localparam int DATA_W    = 32;            // width of every Q-format field
    localparam int VEC       = 3;             // components per vector
    localparam int IN_W      = 11 * DATA_W;   // packed input payload
    localparam int OUT_W     = 32;            // distance padded to whole bytes
    localparam int DIST_W    = 31;
    localparam int CFG_W     = 16;
    localparam int MUL_STEPS = 32;            // one multiplier bit per cycle
    localparam int DIV_STEPS = 32;            // one quotient bit per cycle
    localparam int STEP_W    = 6;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_SLAB  = 1'b1;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // Sequencer strobes for the serial arithmetic units
    typedef struct packed {
        logic load;
        logic init;
        logic step;
        logic last;
    } serial_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_PREP,
        ST_DIV,
        ST_ORD,
        ST_UPD,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/ray_obb_slab_test.sv -----
// Ray against oriented box, slab method, signed fixed point (FRAC_BITS fraction bits).
// Input transfer on s_axis: tuser = cmd (0 start, 1 slab), tdata = a_x, a_y, a_z,
// b_x, b_y, b_z, c_x, c_y, c_z, slab_low, slab_high (32 bits each, a_x lowest).
// A start transfer latches direction b and delta c - a (saturated) and clears the
// bounds. Each of the next AXES slab transfers gives an axis column and its local
// extent. The block forms both dot products with six serial multipliers, then,
// unless the axis is parallel, two serial dividers run side by side. A slab after
// a miss skips the multipliers and dividers and goes straight to the update step.
// Input is taken only in the idle state, so a new slab waits until the last is done.
// The slab that completes AXES axes leaves one result on m_axis: tuser = hit,
// tdata = distance (31 bits, bit 31 zero). The output register holds a result
// while the receiver stalls; the block keeps taking input, and only a second
// result waits for the register to drain. Surplus slabs are dropped.
// cfg_valid/cfg_data write parallel_limit; cfg_ready is always high.
// rst_n clears direction, delta, bounds, count, limit and the output valid bit.
module ray_obb_slab_test #(
    parameter int AXES      = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, slab_low, slab_high
    input  logic [rost_pkg::IN_W-1:0]    s_axis_tdata,
    // cmd
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // distance, then one zero pad bit
    output logic [rost_pkg::OUT_W-1:0]   m_axis_tdata,
    // hit
    output logic                         m_axis_tuser,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rost_pkg::CFG_W-1:0]   cfg_data
);
    import rost_pkg::*;

    localparam int NUM_W = 2 * DATA_W + 2 - FRAC_BITS;
    localparam int AX_W  = $clog2(AXES + 1);
    localparam logic [AX_W-1:0] AXES_N = AX_W'(AXES);

    state_t state_reg, state_next;

    logic signed [DATA_W-1:0] dir_reg   [VEC];
    logic signed [DATA_W-1:0] delta_reg [VEC];
    logic signed [DATA_W-1:0] near_bound_reg;
    logic signed [DATA_W-1:0] far_bound_reg;
    logic                     missed_reg;
    logic [AX_W-1:0]          axis_count_reg;
    logic [CFG_W-1:0]         parallel_limit_reg;
    logic [STEP_W-1:0]        cnt_reg;

    logic signed [DATA_W-1:0] slab_low_reg;
    logic signed [DATA_W-1:0] slab_high_reg;
    logic signed [NUM_W-1:0]  e_reg;
    logic signed [NUM_W-1:0]  f_reg;
    logic signed [DATA_W-1:0] tmin_reg;
    logic signed [DATA_W-1:0] tmax_reg;
    logic                     tighten_reg;

    logic                     out_valid_reg;
    logic                     out_hit_reg;
    logic [DIST_W-1:0]        out_dist_reg;

    logic signed [DATA_W-1:0]   a_vec [VEC];
    logic signed [DATA_W-1:0]   b_vec [VEC];
    logic signed [DATA_W-1:0]   c_vec [VEC];
    logic signed [DATA_W-1:0]   delta_in [VEC];
    logic signed [DATA_W-1:0]   lo_in;
    logic signed [DATA_W-1:0]   hi_in;
    logic [DATA_W:0]            d_wide;
    logic signed [2*DATA_W-1:0] pe [VEC];
    logic signed [2*DATA_W-1:0] pf [VEC];
    logic signed [NUM_W-1:0]    e_sum;
    logic signed [NUM_W-1:0]    f_sum;
    logic signed [NUM_W-1:0]    n_low;
    logic signed [NUM_W-1:0]    n_high;
    logic signed [NUM_W-1:0]    lo_ext;
    logic signed [NUM_W-1:0]    hi_ext;
    logic [NUM_W-1:0]           n_low_mag;
    logic [NUM_W-1:0]           n_high_mag;
    logic [NUM_W-1:0]           f_mag;
    logic                       parallel;
    logic                       extent_miss;
    logic signed [DATA_W-1:0]   t_low;
    logic signed [DATA_W-1:0]   t_high;
    logic signed [DATA_W-1:0]   near_next;
    logic signed [DATA_W-1:0]   far_next;

    logic        in_xfer;
    logic        slab_go;
    logic        slot_free;
    logic        emit;
    serial_ctl_t mul_ctl;
    serial_ctl_t div_ctl;

    // Unpack the input payload and form the saturated box delta
    always_comb
    begin
        for (int i = 0; i < VEC; i++)
        begin
            a_vec[i] = s_axis_tdata[i*DATA_W +: DATA_W];
            b_vec[i] = s_axis_tdata[(VEC+i)*DATA_W +: DATA_W];
            c_vec[i] = s_axis_tdata[(2*VEC+i)*DATA_W +: DATA_W];
            d_wide   = {c_vec[i][DATA_W-1], c_vec[i]} - {a_vec[i][DATA_W-1], a_vec[i]};
            if (d_wide[DATA_W] != d_wide[DATA_W-1])
            begin
                delta_in[i] = d_wide[DATA_W] ? Q_MIN : Q_MAX;
            end
            else
            begin
                delta_in[i] = d_wide[DATA_W-1:0];
            end
        end
        lo_in = s_axis_tdata[3*VEC*DATA_W +: DATA_W];
        hi_in = s_axis_tdata[(3*VEC+1)*DATA_W +: DATA_W];
    end

    assign in_xfer   = s_axis_tvalid & s_axis_tready;
    assign slab_go   = in_xfer && (s_axis_tuser == CMD_SLAB) && (axis_count_reg < AXES_N);
    assign slot_free = !out_valid_reg || m_axis_tready;

    // Serial multipliers: e uses axis . delta, f uses dir . axis
    for (genvar g = 0; g < VEC; g++)
    begin : g_mul
        rost_smul u_mul_e (
            .clk     (clk),
            .ctl     (mul_ctl),
            .mcand   (a_vec[g]),
            .mplier  (delta_reg[g]),
            .product (pe[g])
        );
        rost_smul u_mul_f (
            .clk     (clk),
            .ctl     (mul_ctl),
            .mcand   (dir_reg[g]),
            .mplier  (a_vec[g]),
            .product (pf[g])
        );
    end

    // Floor-shift each product and add the three terms
    always_comb
    begin
        e_sum = '0;
        f_sum = '0;
        for (int i = 0; i < VEC; i++)
        begin
            e_sum = e_sum + {{2{pe[i][2*DATA_W-1]}}, pe[i][2*DATA_W-1:FRAC_BITS]};
            f_sum = f_sum + {{2{pf[i][2*DATA_W-1]}}, pf[i][2*DATA_W-1:FRAC_BITS]};
        end
    end

    // Numerators, magnitudes and the parallel test
    always_comb
    begin
        lo_ext      = NUM_W'(slab_low_reg);
        hi_ext      = NUM_W'(slab_high_reg);
        n_low       = e_reg + lo_ext;
        n_high      = e_reg + hi_ext;
        n_low_mag   = n_low[NUM_W-1] ? -n_low : n_low;
        n_high_mag  = n_high[NUM_W-1] ? -n_high : n_high;
        f_mag       = f_reg[NUM_W-1] ? -f_reg : f_reg;
        parallel    = (f_mag <= NUM_W'(parallel_limit_reg));
        extent_miss = (lo_ext > e_reg) || (hi_ext < e_reg);
    end

    rost_sdiv #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_div_low (
        .clk     (clk),
        .ctl     (div_ctl),
        .num_mag (n_low_mag),
        .den_mag (f_mag),
        .neg     (n_low[NUM_W-1] ^ f_reg[NUM_W-1]),
        .quot    (t_low)
    );

    rost_sdiv #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_div_high (
        .clk     (clk),
        .ctl     (div_ctl),
        .num_mag (n_high_mag),
        .den_mag (f_mag),
        .neg     (n_high[NUM_W-1] ^ f_reg[NUM_W-1]),
        .quot    (t_high)
    );

    // Tighten the running bounds
    always_comb
    begin
        far_next  = (far_bound_reg > tmax_reg) ? tmax_reg : far_bound_reg;
        near_next = (near_bound_reg < tmin_reg) ? tmin_reg : near_bound_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (slab_go)
                begin
                    state_next = missed_reg ? ST_UPD : ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = parallel ? ST_UPD : ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == STEP_W'(DIV_STEPS))
                begin
                    state_next = ST_ORD;
                end
            end
            ST_ORD:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if ((axis_count_reg != AXES_N) || slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        mul_ctl       = '0;
        div_ctl       = '0;
        emit          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                mul_ctl.load  = slab_go && !missed_reg;
            end
            ST_MUL:
            begin
                mul_ctl.step = 1'b1;
                mul_ctl.last = (cnt_reg == STEP_W'(MUL_STEPS - 1));
            end
            ST_PREP:
            begin
                div_ctl.load = !parallel;
            end
            ST_DIV:
            begin
                div_ctl.init = (cnt_reg == '0);
                div_ctl.step = (cnt_reg != '0);
            end
            ST_EMIT:
            begin
                emit = (axis_count_reg == AXES_N) && slot_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_MUL || state_reg == ST_DIV) && state_next == state_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    // Ray state, running bounds and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VEC; i++)
            begin
                dir_reg[i]   <= '0;
                delta_reg[i] <= '0;
            end
            near_bound_reg     <= '0;
            far_bound_reg      <= Q_MAX;
            missed_reg         <= 1'b0;
            axis_count_reg     <= '0;
            tighten_reg        <= 1'b0;
            parallel_limit_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                parallel_limit_reg <= cfg_data;
            end
            if (in_xfer && s_axis_tuser == CMD_START)
            begin
                for (int i = 0; i < VEC; i++)
                begin
                    dir_reg[i]   <= b_vec[i];
                    delta_reg[i] <= delta_in[i];
                end
                near_bound_reg <= '0;
                far_bound_reg  <= Q_MAX;
                missed_reg     <= 1'b0;
                axis_count_reg <= '0;
            end
            if (slab_go)
            begin
                tighten_reg <= 1'b0;
            end
            if (state_reg == ST_PREP)
            begin
                tighten_reg <= !parallel;
                if (parallel && extent_miss)
                begin
                    missed_reg <= 1'b1;
                end
            end
            if (state_reg == ST_UPD)
            begin
                axis_count_reg <= axis_count_reg + 1'b1;
                if (tighten_reg)
                begin
                    near_bound_reg <= near_next;
                    far_bound_reg  <= far_next;
                    if (far_next < near_next)
                    begin
                        missed_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Slab payload, dot products and ordered division results
    always_ff @(posedge clk)
    begin
        if (slab_go)
        begin
            slab_low_reg  <= lo_in;
            slab_high_reg <= hi_in;
        end
        if (state_reg == ST_SUM)
        begin
            e_reg <= e_sum;
            f_reg <= f_sum;
        end
        if (state_reg == ST_ORD)
        begin
            tmin_reg <= (t_low > t_high) ? t_high : t_low;
            tmax_reg <= (t_low > t_high) ? t_low : t_high;
        end
    end

    // Output register: hold the result until the receiver takes the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_hit_reg  <= !missed_reg;
            out_dist_reg <= missed_reg ? '0 : near_bound_reg[DIST_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = {{(OUT_W - DIST_W){1'b0}}, out_dist_reg};
    assign cfg_ready     = 1'b1;

    // Bounds stay ordered and non-negative until a miss
    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        !missed_reg |-> (!near_bound_reg[DATA_W-1] && (near_bound_reg <= far_bound_reg)))
        else $error("near bound above far bound without a miss");

    // The axis count never passes the number of axes
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        axis_count_reg <= AXES_N)
        else $error("axis count beyond AXES");

    // A result appears only out of the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside the emit step");

    // Ordered division results feed the bound update
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && tighten_reg) |-> (tmin_reg <= tmax_reg))
        else $error("slab distances not ordered");

endmodule

// ----- rtl/rost_smul.sv -----
// Bit-serial signed 32x32 multiplier, one multiplier bit per step.
// Depends on rost_pkg for the control struct and data width.
module rost_smul (
    input  logic                                clk,
    input  rost_pkg::serial_ctl_t               ctl,
    input  logic signed [rost_pkg::DATA_W-1:0]  mcand,
    input  logic signed [rost_pkg::DATA_W-1:0]  mplier,
    output logic signed [2*rost_pkg::DATA_W-1:0] product
);
    import rost_pkg::*;

    logic [DATA_W-1:0] mcand_reg;
    logic [DATA_W:0]   hi_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [DATA_W:0]   ext;
    logic [DATA_W:0]   addend;
    logic [DATA_W:0]   sum;

    // Add or, on the sign bit, subtract the multiplicand
    always_comb
    begin
        ext = {mcand_reg[DATA_W-1], mcand_reg};
        if (lo_reg[0])
        begin
            addend = ctl.last ? -ext : ext;
        end
        else
        begin
            addend = '0;
        end
        sum = hi_reg + addend;
    end

    // Shift the partial product right one bit per step
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end
        else if (ctl.step)
        begin
            hi_reg <= {sum[DATA_W], sum[DATA_W:1]};
            lo_reg <= {sum[0], lo_reg[DATA_W-1:1]};
        end
    end

    assign product = {hi_reg[DATA_W-1:0], lo_reg};

endmodule

// ----- rtl/rost_sdiv.sv -----
// Bit-serial restoring divider: saturated fixed-point quotient (n << FRAC_BITS) / d.
// Depends on rost_pkg for the control struct and constants.
module rost_sdiv #(
    parameter int FRAC_BITS = 16,
    parameter int NUM_W     = 50
) (
    input  logic                               clk,
    input  rost_pkg::serial_ctl_t              ctl,
    input  logic [NUM_W-1:0]                   num_mag,
    input  logic [NUM_W-1:0]                   den_mag,
    input  logic                               neg,
    output logic signed [rost_pkg::DATA_W-1:0] quot
);
    import rost_pkg::*;

    localparam int SH = DATA_W - FRAC_BITS;

    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  den_reg;
    logic              neg_reg;
    logic              ovf_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [DATA_W-1:0] dig_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [NUM_W:0]    part;
    logic [NUM_W:0]    diff;
    logic              fits;
    logic              sat;

    // Trial subtract for one quotient bit
    always_comb
    begin
        part = {rem_reg, dig_reg[DATA_W-1]};
        fits = (part >= {1'b0, den_reg});
        diff = part - {1'b0, den_reg};
    end

    // Load operands, check for overflow, then one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            num_reg <= num_mag;
            den_reg <= den_mag;
            neg_reg <= neg;
        end
        else if (ctl.init)
        begin
            // quotient >= 2^32 when n >= d << SH; otherwise the top bits are zero
            ovf_reg <= ({{SH{1'b0}}, num_reg} >= {den_reg, {SH{1'b0}}});
            rem_reg <= num_reg >> SH;
            dig_reg <= {num_reg[SH-1:0], {FRAC_BITS{1'b0}}};
            quo_reg <= '0;
        end
        else if (ctl.step)
        begin
            rem_reg <= fits ? diff[NUM_W-1:0] : part[NUM_W-1:0];
            dig_reg <= {dig_reg[DATA_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    // Apply the sign and clamp to the signed 32-bit range
    always_comb
    begin
        sat = ovf_reg | quo_reg[DATA_W-1];
        if (neg_reg)
        begin
            quot = sat ? Q_MIN : $signed(-quo_reg);
        end
        else
        begin
            quot = sat ? Q_MAX : $signed(quo_reg);
        end
    end

endmodule
